// ===== hdl/assert_macros.svh =====
// assertion macros for the rtl, included by chamber_mode_supervisor.sv
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked check, masked while reset is asserted
`define ASSERT_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// clocked check that also holds during reset
`define ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) (prop)) else $error(msg);

`endif

// ===== hdl/cms_pkg.sv =====
// types and constants of the chamber mode supervisor
`default_nettype none
package cms_pkg;

  typedef enum logic [2:0] {
    MODE_INIT    = 3'd0,
    MODE_IDLE    = 3'd1,
    MODE_RUNNING = 3'd2,
    MODE_ALARM   = 3'd3,
    MODE_STANDBY = 3'd4
  } mode_e;

  localparam logic OP_EVENT = 1'b0;
  localparam logic OP_CHECK = 1'b1;

  // event flag bit positions
  localparam int unsigned EvSensorTimeout = 0;
  localparam int unsigned EvSensorFault   = 1;
  localparam int unsigned EvStart         = 2;
  localparam int unsigned EvStop          = 3;
  localparam int unsigned EvEstop         = 4;
  localparam int unsigned EvOverTemp      = 5;
  localparam int unsigned EvAck           = 6;
  localparam int unsigned EvIdleTimeout   = 7;
  localparam int unsigned EvStable        = 8;
  localparam int unsigned EvFirstReading  = 9;
  localparam int unsigned EvUnstable      = 10;

  localparam logic [10:0] EV_FAULT_MASK = 11'((1 << EvSensorTimeout) | (1 << EvSensorFault) |
                                              (1 << EvEstop) | (1 << EvOverTemp));

  // register indexes on the configuration port
  localparam logic [1:0] REG_TEMP_BAND     = 2'd0;
  localparam logic [1:0] REG_HUM_BAND      = 2'd1;
  localparam logic [1:0] REG_REQUIRED_HITS = 2'd2;

  localparam logic [15:0] TEMP_BAND_RST     = 16'd50;
  localparam logic [13:0] HUM_BAND_RST      = 14'd300;
  localparam logic [15:0] REQUIRED_HITS_RST = 16'd30;
  localparam logic [15:0] HIT_MAX           = 16'hFFFF;

  typedef struct packed {
    logic               opcode;
    logic        [10:0] event_flags;
    logic               snapshot_valid;
    logic signed [15:0] temperature;
    logic        [13:0] humidity;
    logic signed [15:0] target_temperature;
    logic        [13:0] target_humidity;
  } in_word_t;

  typedef struct packed {
    logic [2:0]  mode;
    logic        mode_changed;
    logic        within_band;
    logic        stable_raised;
    logic        unstable_raised;
    logic [15:0] hit_count;
  } out_word_t;

endpackage
`default_nettype wire

// ===== hdl/chamber_mode_supervisor.sv =====
// chamber mode supervisor: input register then result register
// throughput one word per cycle unless the output stalls, mode and hit counter
// update as a word leaves the input register, set by the combinational band
// compare and counter logic; reset clears both registers' valid flags, sets
// mode to init, counter to zero and the band and hit registers to their defaults
`default_nettype none
`include "assert_macros.svh"
module chamber_mode_supervisor (
  input  wire                  clk_i,
  input  wire                  rst_ni,
  input  wire                  in_valid_i,
  output logic                 in_stall_o,
  input  cms_pkg::in_word_t    in_data_i,
  output logic                 out_valid_o,
  input  wire                  out_stall_i,
  output cms_pkg::out_word_t   out_data_o,
  input  wire                  psel,
  input  wire                  penable,
  input  wire                  pwrite,
  input  wire  [3:0]           paddr,
  input  wire  [31:0]          pwdata,
  output logic [31:0]          prdata,
  output logic                 pready
);
  import cms_pkg::*;

  logic [15:0] temp_band_q;
  logic [13:0] hum_band_q;
  logic [15:0] req_hits_q;

  logic      s1_valid_q;
  in_word_t  s1_data_q;
  logic      out_valid_q;
  out_word_t out_data_q;

  mode_e       mode_q, mode_d;
  logic [15:0] cnt_q, cnt_d;
  logic        inb, st_r, un_r;

  logic out_free, s1_move, in_take;

  // configuration port
  assign pready = 1'b1;
  wire cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      temp_band_q <= TEMP_BAND_RST;
      hum_band_q  <= HUM_BAND_RST;
      req_hits_q  <= REQUIRED_HITS_RST;
    end else if (cfg_wr) begin
      unique case (paddr[3:2])
        REG_TEMP_BAND:     temp_band_q <= pwdata[15:0];
        REG_HUM_BAND:      hum_band_q  <= pwdata[13:0];
        REG_REQUIRED_HITS: req_hits_q  <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      REG_TEMP_BAND:     prdata = {16'd0, temp_band_q};
      REG_HUM_BAND:      prdata = {18'd0, hum_band_q};
      REG_REQUIRED_HITS: prdata = {16'd0, req_hits_q};
      default:           prdata = 32'd0;
    endcase
  end

  // pipeline handshake
  assign out_free   = !out_valid_q || !out_stall_i;
  assign s1_move    = s1_valid_q && out_free;
  assign in_take    = !s1_valid_q || out_free;
  assign in_stall_o = !in_take;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      mode_q      <= MODE_INIT;
      cnt_q       <= 16'd0;
    end else begin
      if (in_take) s1_valid_q <= in_valid_i;
      if (out_free) out_valid_q <= s1_valid_q;
      if (s1_move) begin
        mode_q <= mode_d;
        cnt_q  <= cnt_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take && in_valid_i) s1_data_q <= in_data_i;
    if (s1_move) begin
      out_data_q.mode            <= mode_d;
      out_data_q.mode_changed    <= (mode_d != mode_q);
      out_data_q.within_band     <= inb;
      out_data_q.stable_raised   <= st_r;
      out_data_q.unstable_raised <= un_r;
      out_data_q.hit_count       <= cnt_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  // next mode
  logic [10:0] flags;
  assign flags = s1_data_q.event_flags;

  always_comb begin
    mode_d = mode_q;
    if (s1_data_q.opcode == OP_EVENT) begin
      if ((flags & EV_FAULT_MASK) != 11'd0) begin
        mode_d = MODE_ALARM;
      end else begin
        unique case (mode_q)
          MODE_INIT:    if (flags[EvFirstReading]) mode_d = MODE_IDLE;
          MODE_IDLE:    if (flags[EvStart]) mode_d = MODE_RUNNING;
          MODE_RUNNING: begin
            if (flags[EvStop])        mode_d = MODE_IDLE;
            else if (flags[EvStable]) mode_d = MODE_STANDBY;
          end
          MODE_STANDBY: begin
            if (flags[EvStop])          mode_d = MODE_IDLE;
            else if (flags[EvUnstable]) mode_d = MODE_RUNNING;
          end
          MODE_ALARM:   if (flags[EvAck]) mode_d = MODE_IDLE;
          default:      mode_d = MODE_INIT;
        endcase
      end
    end
  end

  // band check and hit counter
  logic signed [16:0] dt_s;
  logic        [16:0] dt;
  logic        [13:0] dh;
  logic        [15:0] cnt_inc;
  logic               active;

  assign dt_s = 17'(s1_data_q.temperature) - 17'(s1_data_q.target_temperature);
  assign dt   = dt_s[16] ? 17'(-dt_s) : 17'(dt_s);
  assign dh   = (s1_data_q.humidity >= s1_data_q.target_humidity)
              ? (s1_data_q.humidity - s1_data_q.target_humidity)
              : (s1_data_q.target_humidity - s1_data_q.humidity);
  assign cnt_inc = (cnt_q < HIT_MAX) ? (cnt_q + 16'd1) : cnt_q;
  assign active  = (mode_q == MODE_RUNNING) || (mode_q == MODE_STANDBY);

  always_comb begin
    inb   = 1'b0;
    st_r  = 1'b0;
    un_r  = 1'b0;
    cnt_d = cnt_q;
    if (s1_data_q.opcode == OP_EVENT) begin
      if (mode_d != mode_q) cnt_d = 16'd0;
    end else if (!active || !s1_data_q.snapshot_valid) begin
      cnt_d = 16'd0;
    end else begin
      inb = (dt < {1'b0, temp_band_q}) && (dh < hum_band_q);
      if (mode_q == MODE_RUNNING) begin
        if (inb) begin
          if (cnt_inc >= req_hits_q) begin
            cnt_d = 16'd0;
            st_r  = 1'b1;
          end else begin
            cnt_d = cnt_inc;
          end
        end else begin
          cnt_d = 16'd0;
        end
      end else if (!inb) begin
        cnt_d = 16'd0;
        un_r  = 1'b1;
      end
    end
  end

  `ASSERT_RST(a_stable_word, out_valid_o && out_data_o.stable_raised |-> out_data_o.mode == MODE_RUNNING && out_data_o.hit_count == 16'd0 && out_data_o.within_band, "stable word inconsistent")
  `ASSERT_RST(a_unstable_word, out_valid_o && out_data_o.unstable_raised |-> out_data_o.mode == MODE_STANDBY && out_data_o.hit_count == 16'd0 && !out_data_o.within_band, "unstable word inconsistent")
  `ASSERT_RST(a_change_clears, out_valid_o && out_data_o.mode_changed |-> out_data_o.hit_count == 16'd0, "mode change kept counter")
  `ASSERT_RST(a_stage_moves, s1_valid_q && out_free |=> out_valid_q, "word lost between stages")

endmodule
`default_nettype wire

// ===== sim/tb.sv =====
// self-checking testbench for the chamber mode supervisor
`timescale 1ns / 1ps
module tb;
  import cms_pkg::*;

  localparam int unsigned StallLimit = 1000;
  localparam int unsigned FaultBits[4] = '{EvSensorTimeout, EvSensorFault, EvEstop, EvOverTemp};

  logic        clk_i;
  logic        rst_ni;
  logic        in_valid_i;
  logic        in_stall_o;
  in_word_t    in_data_i;
  logic        out_valid_o;
  logic        out_stall_i;
  out_word_t   out_data_o;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [3:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  bit calm = 1'b0;
  bit hold_req = 1'b0;

  chamber_mode_supervisor dut (.*);

  // tracks mode and hit counter, holds the status words still to come out
  class mode_scoreboard;
    mode_e       mode;
    logic [15:0] hits;
    logic [15:0] temp_band;
    logic [13:0] hum_band;
    logic [15:0] need_hits;
    out_word_t   expected_status[$];
    int unsigned seen;
    int unsigned errors;

    function new();
      mode      = MODE_INIT;
      hits      = '0;
      temp_band = TEMP_BAND_RST;
      hum_band  = HUM_BAND_RST;
      need_hits = REQUIRED_HITS_RST;
      seen      = 0;
      errors    = 0;
    endfunction

    function void set_reg(logic [1:0] idx, logic [31:0] val);
      case (idx)
        REG_TEMP_BAND: temp_band = val[15:0];
        REG_HUM_BAND: hum_band = val[13:0];
        REG_REQUIRED_HITS: need_hits = val[15:0];
        default: ;
      endcase
    endfunction

    function void move_to(mode_e nxt);
      if (nxt != mode) hits = '0;
      mode = nxt;
    endfunction

    function void note_word(in_word_t w);
      mode_e       prev;
      out_word_t   s;
      logic [10:0] f;
      logic        in_band;
      logic        stab;
      logic        unstab;
      int          dt;
      int          dh;
      prev    = mode;
      f       = w.event_flags;
      in_band = 1'b0;
      stab    = 1'b0;
      unstab  = 1'b0;
      if (w.opcode == OP_EVENT) begin
        // faults win over every other flag
        if ((f & EV_FAULT_MASK) != '0) begin
          move_to(MODE_ALARM);
        end else begin
          case (mode)
            MODE_INIT: begin
              if (f[EvFirstReading]) move_to(MODE_IDLE);
            end
            MODE_IDLE: begin
              if (f[EvStart]) move_to(MODE_RUNNING);
            end
            MODE_RUNNING: begin
              if (f[EvStop]) move_to(MODE_IDLE);
              else if (f[EvStable]) move_to(MODE_STANDBY);
            end
            MODE_STANDBY: begin
              if (f[EvStop]) move_to(MODE_IDLE);
              else if (f[EvUnstable]) move_to(MODE_RUNNING);
            end
            MODE_ALARM: begin
              if (f[EvAck]) move_to(MODE_IDLE);
            end
            default: ;
          endcase
        end
      end else if ((mode != MODE_RUNNING && mode != MODE_STANDBY) || !w.snapshot_valid) begin
        hits = '0;
      end else begin
        dt = $signed(w.temperature) - $signed(w.target_temperature);
        dh = int'(w.humidity) - int'(w.target_humidity);
        if (dt < 0) dt = -dt;
        if (dh < 0) dh = -dh;
        in_band = (dt < int'(temp_band)) && (dh < int'(hum_band));
        if (mode == MODE_RUNNING) begin
          if (in_band) begin
            if (hits != HIT_MAX) hits = hits + 16'd1;
            if (hits >= need_hits) begin
              hits = '0;
              stab = 1'b1;
            end
          end else begin
            hits = '0;
          end
        end else if (!in_band) begin
          hits   = '0;
          unstab = 1'b1;
        end
      end
      s.mode            = mode;
      s.mode_changed    = (mode != prev);
      s.within_band     = in_band;
      s.stable_raised   = stab;
      s.unstable_raised = unstab;
      s.hit_count       = hits;
      expected_status.push_back(s);
    endfunction

    function void check_status(out_word_t got);
      out_word_t want;
      seen++;
      if (expected_status.size() == 0) begin
        errors++;
        if (errors <= 10) $display("status word %0d arrived with nothing expected", seen);
      end else begin
        want = expected_status.pop_front();
        if (got !== want) begin
          errors++;
          if (errors <= 10) begin
            $display("status word %0d: mode %0d/%0d chg %b/%b band %b/%b stable %b/%b",
                     seen, want.mode, got.mode, want.mode_changed, got.mode_changed,
                     want.within_band, got.within_band, want.stable_raised,
                     got.stable_raised);
            $display("  unstable %b/%b hits %0d/%0d (expected/actual)",
                     want.unstable_raised, got.unstable_raised, want.hit_count,
                     got.hit_count);
          end
        end
      end
    endfunction

    function int pending();
      return expected_status.size();
    endfunction
  endclass

  mode_scoreboard sb = new();

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  function automatic bit chance(int unsigned pct);
    return $urandom_range(99) < pct;
  endfunction

  function automatic logic [10:0] ev_bit(int unsigned pos);
    return 11'(1) << pos;
  endfunction

  function automatic in_word_t make_event(logic [10:0] flags);
    in_word_t w;
    w             = '0;
    w.opcode      = OP_EVENT;
    w.event_flags = flags;
    return w;
  endfunction

  function automatic in_word_t make_check(logic vld, logic signed [15:0] t,
                                          logic signed [15:0] tt, logic [13:0] h,
                                          logic [13:0] th);
    in_word_t w;
    w                    = '0;
    w.opcode             = OP_CHECK;
    w.snapshot_valid     = vld;
    w.temperature        = t;
    w.target_temperature = tt;
    w.humidity           = h;
    w.target_humidity    = th;
    return w;
  endfunction

  // deviation just inside or outside a band
  function automatic int pick_dev(int band, bit want_in);
    if (want_in && band > 0) return $urandom_range(band - 1);
    return band + $urandom_range(300);
  endfunction

  function automatic int place(int centre, int dev, int lo, int hi);
    if (chance(50)) dev = -dev;
    if (centre + dev > hi || centre + dev < lo) dev = -dev;
    if (centre + dev > hi || centre + dev < lo) return lo + $urandom_range(hi - lo);
    return centre + dev;
  endfunction

  // mostly checks near the bands, else the next sensible event for the current mode or a raw random word
  function automatic in_word_t make_random_word();
    in_word_t    w;
    logic [95:0] raw;
    logic [10:0] flags;
    int          r;
    int          tt;
    int          th;
    raw = {$urandom, $urandom, $urandom};
    w   = raw[$bits(in_word_t)-1:0];
    r   = $urandom_range(99);
    if (r < 5) return w;
    if (r < 40) begin
      flags = '0;
      case (sb.mode)
        MODE_INIT: begin
          if (chance(60)) flags |= ev_bit(EvFirstReading);
        end
        MODE_IDLE: begin
          if (chance(60)) flags |= ev_bit(EvStart);
        end
        MODE_RUNNING: begin
          if (chance(40)) flags |= ev_bit(EvStable);
          if (chance(10)) flags |= ev_bit(EvStop);
        end
        MODE_STANDBY: begin
          if (chance(30)) flags |= ev_bit(EvUnstable);
          if (chance(10)) flags |= ev_bit(EvStop);
        end
        MODE_ALARM: begin
          if (chance(60)) flags |= ev_bit(EvAck);
        end
        default: ;
      endcase
      if (chance(15)) flags |= 11'($urandom) & ~EV_FAULT_MASK;
      if (chance(4)) flags |= ev_bit(FaultBits[$urandom_range(3)]);
      w.opcode      = OP_EVENT;
      w.event_flags = flags;
    end else begin
      tt = int'($urandom_range(65535)) - 32768;
      th = $urandom_range(16383);
      w.opcode             = OP_CHECK;
      w.snapshot_valid     = chance(95);
      w.target_temperature = 16'(tt);
      w.target_humidity    = 14'(th);
      w.temperature = 16'(place(tt, pick_dev(int'(sb.temp_band), chance(80)), -32768, 32767));
      w.humidity    = 14'(place(th, pick_dev(int'(sb.hum_band), chance(85)), 0, 16383));
    end
    return w;
  endfunction

  task automatic send_word(input in_word_t w);
    if (!calm && chance(7)) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(5, 1)) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= w;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    sb.note_word(w);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [31:0] val);
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= val;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    sb.set_reg(idx, val);
  endtask

  // stop offering, let every status word drain and the pipe go quiet
  task automatic settle();
    in_valid_i <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic run_phase(input int unsigned n, input logic [31:0] t_band,
                           input logic [31:0] h_band, input logic [31:0] hits_req,
                           input bit stress);
    settle();
    write_reg(REG_TEMP_BAND, t_band);
    write_reg(REG_HUM_BAND, h_band);
    write_reg(REG_REQUIRED_HITS, hits_req);
    for (int unsigned k = 0; k < n; k++) begin
      calm = stress && (k < 150);
      if (stress && k == 250) hold_req = 1'b1;
      send_word(make_random_word());
    end
    calm = 1'b0;
  endtask

  initial begin : receiver
    int hold_left;
    hold_left = 0;
    out_stall_i <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_req) begin
        hold_req  = 1'b0;
        hold_left = 64;
      end
      if (hold_left > 0) begin
        out_stall_i <= 1'b1;
        hold_left--;
      end else begin
        out_stall_i <= !calm && chance(7);
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) sb.check_status(out_data_o);
  end

  initial begin : watchdog
    int unsigned stuck;
    stuck = 0;
    while (stuck < StallLimit) begin
      @(posedge clk_i);
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) stuck = 0;
      else stuck++;
    end
    $display("chamber_mode_supervisor: mismatch");
    $finish;
  end

  initial begin : stimulus
    rst_ni     <= 1'b0;
    in_valid_i <= 1'b0;
    in_data_i  <= '0;
    psel       <= 1'b0;
    penable    <= 1'b0;
    pwrite     <= 1'b0;
    paddr      <= '0;
    pwdata     <= '0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;

    // short stable count so the directed part raises the stable flag
    write_reg(REG_REQUIRED_HITS, 32'd2);
    send_word(make_check(1'b1, 16'sd100, 16'sd100, 14'd0, 14'd0));
    send_word(make_event(ev_bit(EvIdleTimeout)));
    send_word(make_event(ev_bit(EvFirstReading) | ev_bit(EvStart)));
    send_word(make_event(ev_bit(EvStart)));
    send_word(make_check(1'b0, 16'sd0, 16'sd0, 14'd0, 14'd0));
    send_word(make_check(1'b1, 16'sd32767, 16'sd32718, 14'd16383, 14'd16084));
    send_word(make_check(1'b1, -16'sd32768, -16'sd32767, 14'd0, 14'd1));
    // deviation equal to the band is out
    send_word(make_check(1'b1, 16'sd0, 16'sd50, 14'd0, 14'd0));
    send_word(make_check(1'b1, 16'sd10, 16'sd10, 14'd5000, 14'd5300));
    send_word(make_check(1'b1, 16'sd0, 16'sd0, 14'd0, 14'd0));
    send_word(make_event(ev_bit(EvStable) | ev_bit(EvUnstable) | ev_bit(EvIdleTimeout)));
    send_word(make_check(1'b1, 16'sd5, 16'sd0, 14'd0, 14'd0));
    // widest possible temperature deviation
    send_word(make_check(1'b1, 16'sd32767, -16'sd32768, 14'd0, 14'd0));
    send_word(make_event(ev_bit(EvUnstable)));
    send_word(make_event(ev_bit(EvStop) | ev_bit(EvStable)));
    send_word(make_event(ev_bit(EvStart)));
    send_word(make_check(1'b1, 16'sd0, 16'sd0, 14'd0, 14'd0));
    send_word(make_event(ev_bit(EvEstop) | ev_bit(EvAck)));
    send_word(make_event(ev_bit(EvSensorFault) | ev_bit(EvAck)));
    send_word(make_event(ev_bit(EvAck)));
    send_word(make_event(ev_bit(EvOverTemp)));
    send_word(make_event(ev_bit(EvSensorTimeout)));
    send_word(make_event(11'h7FF));
    send_word(make_event(ev_bit(EvAck)));
    send_word(make_event('0));

    run_phase(400, 32'd200, 32'd500, 32'd3, 1'b1);
    run_phase(250, 32'd0, 32'd0, 32'd1, 1'b0);
    run_phase(250, 32'd65535, 32'd10000, 32'd65535, 1'b0);
    run_phase(350, 32'd120, 32'd250, 32'd0, 1'b0);
    run_phase(300, 32'd50, 32'd300, 32'd30, 1'b0);
    run_phase(200, $urandom_range(400, 1), $urandom_range(600, 1), $urandom_range(6, 1), 1'b0);
    run_phase(200, $urandom_range(65535), $urandom_range(10000), $urandom_range(4, 1), 1'b0);

    settle();
    repeat (8) @(posedge clk_i);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("chamber_mode_supervisor: match");
    end else begin
      $display("chamber_mode_supervisor: mismatch");
    end
    $finish;
  end

endmodule

// ===== chamber_mode_supervisor.f =====
+incdir+hdl
hdl/cms_pkg.sv
hdl/chamber_mode_supervisor.sv
sim/tb.sv
